// ===== rtl/core/hrp_pkg.sv =====
package hrp_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned NIB_W  = 4;
    localparam int unsigned EV_W   = 3;
    localparam int unsigned ADDR_W = 16;

    typedef logic [CHAR_W-1:0] t_char;
    typedef logic [NIB_W-1:0]  t_nibble;
    typedef logic [EV_W-1:0]   t_event;

    // ascii codes
    localparam t_char CH_COLON   = 8'h3A;
    localparam t_char CH_CR      = 8'd13;
    localparam t_char CH_LF      = 8'd10;
    localparam t_char CH_ZERO    = 8'd48;
    localparam t_char CH_NINE    = 8'd57;
    localparam t_char CH_UPPER_A = 8'd65;
    localparam t_char CH_UPPER_F = 8'd70;
    localparam t_char HEX_A_VAL  = 8'd10;

    // record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    // result codes
    localparam t_event EV_DATA      = 3'd0;
    localparam t_event EV_OK        = 3'd1;
    localparam t_event EV_EOF       = 3'd2;
    localparam t_event EV_BAD_START = 3'd3;
    localparam t_event EV_BAD_DIGIT = 3'd4;
    localparam t_event EV_MISMATCH  = 3'd5;

    typedef struct packed {
        logic    is_hex;
        t_nibble value;
    } t_digit;

endpackage

// ===== rtl/core/hex_record_parser_unit.sv =====
// path: a character beat accepted into the input register gives its result (if any)
//   through the result register, and waits in the input register while the result slot is full
// throughput: one character per cycle; a beat with a result stalls on a full result slot
// reset: i_rst_n synchronous active low; returns to waiting for a start code and clears
//   the record fields, the running sum and any halt after end of file or an error
module hex_record_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_data_value,
    output logic [15:0] o_byte_address,
    output logic [7:0]  o_kind_of_record,
    output logic [7:0]  o_record_length
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_COUNT,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_SUM,
        PH_HALT
    } t_phase;

    t_phase          r_phase, n_phase;
    logic            r_second, n_second;
    logic [3:0]      r_high, n_high;
    logic            r_step, n_step;
    logic [7:0]      r_count, n_count;
    logic [15:0]     r_addr, n_addr;
    logic [7:0]      r_type, n_type;
    logic [7:0]      r_index, n_index;
    logic [7:0]      r_sum, n_sum;

    logic            r_in_valid;
    hrp_pkg::t_char  r_char;

    logic            r_out_valid;
    hrp_pkg::t_event r_event, n_event;
    logic [7:0]      r_value, n_value;
    logic [15:0]     r_out_addr, n_out_addr;

    hrp_pkg::t_digit w_digit;
    logic            w_has_res;
    logic            w_fire;
    logic [7:0]      w_byte;
    logic [7:0]      w_sum;
    logic [7:0]      w_index_inc;

    hrp_digit u_digit (
        .i_char  (r_char),
        .o_digit (w_digit)
    );

    assign w_byte      = {r_high, w_digit.value};
    assign w_sum       = r_sum + w_byte;
    assign w_index_inc = r_index + 8'd1;

    always_comb begin
        n_phase    = r_phase;
        n_second   = r_second;
        n_high     = r_high;
        n_step     = r_step;
        n_count    = r_count;
        n_addr     = r_addr;
        n_type     = r_type;
        n_index    = r_index;
        n_sum      = r_sum;
        w_has_res  = 1'b0;
        n_event    = hrp_pkg::EV_OK;
        n_value    = '0;
        n_out_addr = r_addr;
        unique case (r_phase)
            PH_HALT: begin
            end
            PH_WAIT: begin
                if (r_char == hrp_pkg::CH_COLON) begin
                    n_phase  = PH_COUNT;
                    n_second = 1'b0;
                    n_high   = '0;
                    n_step   = 1'b0;
                    n_index  = '0;
                    n_sum    = '0;
                end else if (r_char != hrp_pkg::CH_CR && r_char != hrp_pkg::CH_LF) begin
                    n_phase   = PH_HALT;
                    w_has_res = 1'b1;
                    n_event   = hrp_pkg::EV_BAD_START;
                end
            end
            PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_SUM: begin
                if (!w_digit.is_hex) begin
                    n_phase   = PH_HALT;
                    w_has_res = 1'b1;
                    n_event   = hrp_pkg::EV_BAD_DIGIT;
                end else if (!r_second) begin
                    n_high   = w_digit.value;
                    n_second = 1'b1;
                end else begin
                    n_second = 1'b0;
                    n_sum    = w_sum;
                    unique case (r_phase)
                        PH_COUNT: begin
                            n_count = w_byte;
                            n_step  = 1'b0;
                            n_phase = PH_ADDR;
                        end
                        PH_ADDR: begin
                            if (!r_step) begin
                                n_addr = {w_byte, 8'h00};
                                n_step = 1'b1;
                            end else begin
                                n_addr  = {r_addr[15:8], w_byte};
                                n_step  = 1'b0;
                                n_phase = PH_TYPE;
                            end
                        end
                        PH_TYPE: begin
                            n_type  = w_byte;
                            n_index = '0;
                            n_phase = (r_count == 8'd0) ? PH_SUM : PH_DATA;
                        end
                        PH_DATA: begin
                            n_index = w_index_inc;
                            if (w_index_inc == r_count) begin
                                n_phase = PH_SUM;
                            end
                            if (r_type == hrp_pkg::REC_DATA) begin
                                w_has_res  = 1'b1;
                                n_event    = hrp_pkg::EV_DATA;
                                n_value    = w_byte;
                                n_out_addr = r_addr + {8'h00, r_index};
                            end
                        end
                        default: begin
                            // checksum byte
                            w_has_res = 1'b1;
                            if (w_sum != 8'd0) begin
                                n_phase = PH_HALT;
                                n_event = hrp_pkg::EV_MISMATCH;
                            end else if (r_type == hrp_pkg::REC_EOF) begin
                                n_phase = PH_HALT;
                                n_event = hrp_pkg::EV_EOF;
                            end else begin
                                n_phase = PH_WAIT;
                                n_event = hrp_pkg::EV_OK;
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase
    end

    // the held beat moves on unless it has a result and the result slot is full and not being taken
    assign w_fire     = r_in_valid && (!w_has_res || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        // payload registers, no reset needed
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_code;
        end
        if (w_fire && w_has_res) begin
            r_event          <= n_event;
            r_value          <= n_value;
            r_out_addr       <= n_out_addr;
            o_kind_of_record <= r_type;
            o_record_length  <= r_count;
        end
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_second    <= 1'b0;
            r_high      <= '0;
            r_step      <= 1'b0;
            r_count     <= '0;
            r_addr      <= '0;
            r_type      <= '0;
            r_index     <= '0;
            r_sum       <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_phase  <= n_phase;
                r_second <= n_second;
                r_high   <= n_high;
                r_step   <= n_step;
                r_count  <= n_count;
                r_addr   <= n_addr;
                r_type   <= n_type;
                r_index  <= n_index;
                r_sum    <= n_sum;
            end
            if (w_fire && w_has_res) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_event;
    assign o_data_value   = r_value;
    assign o_byte_address = r_out_addr;

    // errors and end of file leave the parser halted
    a_halt_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event != hrp_pkg::EV_DATA && r_event != hrp_pkg::EV_OK)
            |-> (r_phase == PH_HALT))
        else $error("final event without halt");

    // data beats only come from type-00 records
    a_data_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event == hrp_pkg::EV_DATA)
            |-> (o_kind_of_record == hrp_pkg::REC_DATA))
        else $error("data event from a non-data record");

    // no half byte survives into the wait for a start code
    a_wait_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT) |-> !r_second)
        else $error("nibble pending while waiting for start");

    // a held beat that cannot move keeps its character
    a_hold_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_fire) |=> (r_in_valid && $stable(r_char)))
        else $error("held character lost");

endmodule

// ===== rtl/core/hrp_digit.sv =====
module hrp_digit (
    input  hrp_pkg::t_char  i_char,
    output hrp_pkg::t_digit o_digit
);

    hrp_pkg::t_char w_off_num;
    hrp_pkg::t_char w_off_alpha;
    logic           w_is_num;
    logic           w_is_alpha;

    assign w_is_num    = (i_char >= hrp_pkg::CH_ZERO) && (i_char <= hrp_pkg::CH_NINE);
    assign w_is_alpha  = (i_char >= hrp_pkg::CH_UPPER_A) && (i_char <= hrp_pkg::CH_UPPER_F);
    assign w_off_num   = i_char - hrp_pkg::CH_ZERO;
    assign w_off_alpha = i_char - hrp_pkg::CH_UPPER_A + hrp_pkg::HEX_A_VAL;

    always_comb begin
        o_digit.is_hex = w_is_num || w_is_alpha;
        if (w_is_num) begin
            o_digit.value = w_off_num[hrp_pkg::NIB_W-1:0];
        end else if (w_is_alpha) begin
            o_digit.value = w_off_alpha[hrp_pkg::NIB_W-1:0];
        end else begin
            o_digit.value = '0;
        end
    end

endmodule

// ===== sim/hex_record_parser_checker.sv =====
`timescale 1ns / 100ps

module hex_record_parser_checker
    import hrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_char       i_char_code,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_event      i_event_res,
    input  logic [7:0]  i_data_value,
    input  logic [15:0] i_byte_address,
    input  logic [7:0]  i_kind_of_record,
    input  logic [7:0]  i_record_length,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_COUNT,
        PH_ADDR,
        PH_TYPE,
        PH_DATA,
        PH_SUM,
        PH_HALT
    } t_phase;

    typedef struct packed {
        t_event      ev;
        logic [7:0]  value;
        logic [15:0] addr;
        logic [7:0]  kind;
        logic [7:0]  len;
    } t_report;

    t_phase      phase;
    logic        low_digit_next;
    t_nibble     held_high;
    logic        addr_low_next;
    logic [7:0]  rec_len;
    logic [15:0] rec_addr;
    logic [7:0]  rec_kind;
    logic [7:0]  bytes_taken;
    logic [7:0]  line_sum;

    t_report expected_reports[$];
    int      fail_count = 0;
    int      checked = 0;

    function automatic t_digit decode_hex(input t_char c);
        t_digit d;
        d.is_hex = 1'b1;
        d.value  = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.value = t_nibble'(c - CH_ZERO);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
            d.value = t_nibble'(c - CH_UPPER_A + HEX_A_VAL);
        end else begin
            d.is_hex = 1'b0;
        end
        return d;
    endfunction

    task automatic note_report(input t_event ev, input logic [7:0] value,
                               input logic [15:0] addr);
        t_report r;
        r.ev    = ev;
        r.value = value;
        r.addr  = addr;
        r.kind  = rec_kind;
        r.len   = rec_len;
        expected_reports.push_back(r);
    endtask

    task automatic parse_char(input t_char c);
        t_digit      d;
        logic [7:0]  byte_v;
        logic [15:0] addr;
        d = decode_hex(c);
        case (phase)
            PH_HALT: ;
            PH_WAIT: begin
                if (c == CH_COLON) begin
                    phase          = PH_COUNT;
                    low_digit_next = 1'b0;
                    held_high      = '0;
                    addr_low_next  = 1'b0;
                    bytes_taken    = '0;
                    line_sum       = '0;
                end else if (c != CH_CR && c != CH_LF) begin
                    // fields still show the previous record
                    phase = PH_HALT;
                    note_report(EV_BAD_START, 8'h00, rec_addr);
                end
            end
            default: begin
                if (!d.is_hex) begin
                    phase = PH_HALT;
                    note_report(EV_BAD_DIGIT, 8'h00, rec_addr);
                end else if (!low_digit_next) begin
                    held_high      = d.value;
                    low_digit_next = 1'b1;
                end else begin
                    low_digit_next = 1'b0;
                    byte_v         = {held_high, d.value};
                    line_sum       = line_sum + byte_v;
                    case (phase)
                        PH_COUNT: begin
                            rec_len       = byte_v;
                            addr_low_next = 1'b0;
                            phase         = PH_ADDR;
                        end
                        PH_ADDR: begin
                            if (!addr_low_next) begin
                                rec_addr      = {byte_v, 8'h00};
                                addr_low_next = 1'b1;
                            end else begin
                                rec_addr[7:0] = byte_v;
                                addr_low_next = 1'b0;
                                phase         = PH_TYPE;
                            end
                        end
                        PH_TYPE: begin
                            rec_kind    = byte_v;
                            bytes_taken = '0;
                            phase       = (rec_len == 8'h00) ? PH_SUM : PH_DATA;
                        end
                        PH_DATA: begin
                            addr        = rec_addr + 16'(bytes_taken);
                            bytes_taken = bytes_taken + 8'd1;
                            if (bytes_taken == rec_len) phase = PH_SUM;
                            if (rec_kind == REC_DATA) note_report(EV_DATA, byte_v, addr);
                        end
                        default: begin
                            if (line_sum != 8'h00) begin
                                phase = PH_HALT;
                                note_report(EV_MISMATCH, 8'h00, rec_addr);
                            end else if (rec_kind == REC_EOF) begin
                                phase = PH_HALT;
                                note_report(EV_EOF, 8'h00, rec_addr);
                            end else begin
                                phase = PH_WAIT;
                                note_report(EV_OK, 8'h00, rec_addr);
                            end
                        end
                    endcase
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_report want;
        if (!i_rst_n) begin
            phase          = PH_WAIT;
            low_digit_next = 1'b0;
            held_high      = '0;
            addr_low_next  = 1'b0;
            rec_len        = '0;
            rec_addr       = '0;
            rec_kind       = '0;
            bytes_taken    = '0;
            line_sum       = '0;
            expected_reports.delete();
        end else begin
            // result beat first: it always belongs to an older character
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result: ev %0d val %02h addr %04h kind %02h len %02h",
                                 i_event_res, i_data_value, i_byte_address,
                                 i_kind_of_record, i_record_length);
                    end
                end else begin
                    want = expected_reports.pop_front();
                    checked++;
                    if (want.ev !== i_event_res || want.value !== i_data_value ||
                        want.addr !== i_byte_address || want.kind !== i_kind_of_record ||
                        want.len !== i_record_length) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: want ev %0d val %02h addr %04h kind %02h len %02h",
                                     want.ev, want.value, want.addr, want.kind, want.len);
                            $display("           got ev %0d val %02h addr %04h kind %02h len %02h",
                                     i_event_res, i_data_value, i_byte_address,
                                     i_kind_of_record, i_record_length);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) parse_char(i_char_code);
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_reports.size();
        o_checked    <= checked;
    end

endmodule

// ===== sim/tb_hex_record_parser_unit.sv =====
`timescale 1ns / 100ps

module tb_hex_record_parser_unit;
    import hrp_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_CHARS = 900;

    typedef enum int {
        END_EOF,
        END_BAD_START,
        END_BAD_DIGIT,
        END_MISMATCH
    } t_ending;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  in_valid = 1'b0;
    t_char char_code = '0;
    logic  out_ready = 1'b0;

    logic        in_ready;
    logic        out_valid;
    t_event      event_res;
    logic [7:0]  data_value;
    logic [15:0] byte_address;
    logic [7:0]  kind_of_record;
    logic [7:0]  record_length;

    int fail_count;
    int pending;
    int checked;

    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    int          rx_stall = 0;
    int unsigned cycle_count = 0;
    int          chars_sent = 0;
    int          records_sent = 0;

    always #5 clk = ~clk;

    hex_record_parser_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_char_code      (char_code),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_event_res      (event_res),
        .o_data_value     (data_value),
        .o_byte_address   (byte_address),
        .o_kind_of_record (kind_of_record),
        .o_record_length  (record_length)
    );

    hex_record_parser_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_char_code      (char_code),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_event_res      (event_res),
        .i_data_value     (data_value),
        .i_byte_address   (byte_address),
        .i_kind_of_record (kind_of_record),
        .i_record_length  (record_length),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    // result side: a fresh random stall, possibly none, after every accepted beat
    always @(posedge clk) begin : result_sink
        int n;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_stall  <= 0;
        end else if (out_ready && out_valid) begin
            if ($urandom_range(0, 19) == 0) rx_burst <= ~rx_burst;
            n = rx_burst ? 0 : $urandom_range(0, 10);
            out_ready <= (n == 0);
            rx_stall  <= n;
        end else if (!out_ready) begin
            if (rx_stall <= 1) out_ready <= 1'b1;
            rx_stall <= rx_stall - 1;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_char hex_char(input t_nibble n);
        if ({4'h0, n} < HEX_A_VAL) return CH_ZERO + {4'h0, n};
        return CH_UPPER_A + {4'h0, n} - HEX_A_VAL;
    endfunction

    function automatic t_char non_hex_char();
        t_char c;
        case ($urandom_range(0, 9))
            0: c = CH_ZERO - 8'd1;
            1: c = CH_NINE + 8'd1;
            2: c = CH_UPPER_A - 8'd1;
            3: c = CH_UPPER_F + 8'd1;
            4: c = CH_UPPER_A + 8'd32 + 8'($urandom_range(0, 5));
            5: c = CH_CR;
            6: c = CH_LF;
            default: begin
                do c = 8'($urandom);
                while ((c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UPPER_A && c <= CH_UPPER_F));
            end
        endcase
        return c;
    endfunction

    // valid stays up across back-to-back beats, lowered only ahead of a gap
    task automatic send_char(input t_char c);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        do @(posedge clk); while (!in_ready);
        chars_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // bad_at picks a digit to replace with a non-hex character, -1 for none
    task automatic send_record(input logic [7:0] len, input logic [15:0] addr,
                               input logic [7:0] kind, input bit corrupt_sum,
                               input int bad_at, input bit extreme_data);
        logic [7:0] rec_bytes[$];
        logic [7:0] sum;
        int         k;
        t_char      c;
        tx_burst = ($urandom_range(0, 3) == 0);
        rec_bytes.push_back(len);
        rec_bytes.push_back(addr[15:8]);
        rec_bytes.push_back(addr[7:0]);
        rec_bytes.push_back(kind);
        for (k = 0; k < len; k++) begin
            if (extreme_data) rec_bytes.push_back(k[0] ? 8'hFF : 8'h00);
            else rec_bytes.push_back(8'($urandom));
        end
        sum = 8'h00;
        for (k = 0; k < rec_bytes.size(); k++) sum = sum + rec_bytes[k];
        sum = -sum;
        if (corrupt_sum) sum = sum ^ 8'($urandom_range(1, 255));
        rec_bytes.push_back(sum);
        send_char(CH_COLON);
        for (k = 0; k < 2 * rec_bytes.size(); k++) begin
            c = hex_char(k[0] ? rec_bytes[k / 2][3:0] : rec_bytes[k / 2][7:4]);
            if (k == bad_at) c = non_hex_char();
            send_char(c);
        end
        case ($urandom_range(0, 3))
            0: ;
            1: begin
                send_char(CH_CR);
                send_char(CH_LF);
            end
            2: send_char(CH_LF);
            default: send_char(CH_CR);
        endcase
        records_sent++;
    endtask

    initial begin : stimulus
        t_ending     ending;
        int          k;
        int          start;
        logic [7:0]  len;
        logic [7:0]  kind;
        logic [15:0] a;
        t_char       c;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // line ends before any record, empty record, wrap past ffff, non-data type
        send_char(CH_CR);
        send_char(CH_LF);
        send_record(8'd0, 16'hFFFF, REC_DATA, 1'b0, -1, 1'b0);
        send_record(8'd3, 16'hFFFE, REC_DATA, 1'b0, -1, 1'b1);
        send_record(8'd1, 16'h0000, 8'hFF, 1'b0, -1, 1'b1);

        start = chars_sent;
        k = 0;
        while (chars_sent - start < RANDOM_CHARS) begin
            if (k == 8) len = 8'd255;
            else if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(9, 40));
            else len = 8'($urandom_range(0, 8));
            kind = ($urandom_range(0, 2) != 0) ? REC_DATA : 8'($urandom_range(2, 255));
            if ($urandom_range(0, 7) == 0) a = 16'($urandom_range(16'hFFF0, 16'hFFFF));
            else a = 16'($urandom);
            send_record(len, a, kind, 1'b0, -1, 1'b0);
            if (k == 20) wait_drained();
            k++;
        end

        // one terminating condition per run, everything after it is ignored
        ending = t_ending'($urandom_range(0, 3));
        len  = 8'($urandom_range(0, 4));
        a    = 16'($urandom);
        kind = ($urandom_range(0, 1) != 0) ? REC_DATA : 8'($urandom_range(2, 255));
        case (ending)
            END_EOF: send_record(len, a, REC_EOF, 1'b0, -1, 1'b0);
            END_BAD_START: begin
                do c = 8'($urandom);
                while (c == CH_COLON || c == CH_CR || c == CH_LF);
                send_char(c);
            end
            END_BAD_DIGIT: send_record(len, a, kind, 1'b0,
                                       $urandom_range(0, 2 * (len + 5) - 1), 1'b0);
            default: send_record(len, a, kind, 1'b1, -1, 1'b0);
        endcase
        tx_burst = 1'b0;
        for (k = 0; k < 40; k++) send_char(8'($urandom));

        wait_drained();
        repeat (20) @(posedge clk);

        $display("sent %0d characters in %0d records, %0d results checked, %0d mismatches",
                 chars_sent, records_sent, checked, fail_count);
        $display("stream ended by %s, then noise while halted", ending.name());
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
